[rtl/framed_command_receiver_assert.svh]
// Assertion macros shared by the receiver modules.
// Each macro expects clk and rst_n to be visible in the enclosing module.
`ifndef FRAMED_COMMAND_RECEIVER_ASSERT_SVH
`define FRAMED_COMMAND_RECEIVER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define FCR_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define FCR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/fcr_pkg.sv]
package fcr_pkg;

    localparam int MAX_PAYLOAD_DEFAULT = 16;
    localparam int QUEUE_DEPTH_DEFAULT = 2;

    localparam int CFG_INDEX_W = 3;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] CFG_START_BYTE   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_END_BYTE     = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_PERIOD_CODE  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_VIEW_CODE    = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_HIGHEST_VIEW = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_DEFAULT_VIEW = 3'd5;

    // Configuration reset values.
    localparam logic [7:0] START_BYTE_RST   = 8'd170;
    localparam logic [7:0] END_BYTE_RST     = 8'd85;
    localparam logic [7:0] PERIOD_CODE_RST  = 8'd1;
    localparam logic [7:0] VIEW_CODE_RST    = 8'd2;
    localparam logic [7:0] HIGHEST_VIEW_RST = 8'd2;
    localparam logic [7:0] DEFAULT_VIEW_RST = 8'd0;

    // Status codes.
    localparam logic [1:0] ST_NONE = 2'd0;
    localparam logic [1:0] ST_OK   = 2'd1;
    localparam logic [1:0] ST_ERR  = 2'd2;

    // Error codes.
    localparam logic [2:0] E_NONE  = 3'd0;
    localparam logic [2:0] E_LEN   = 3'd1;
    localparam logic [2:0] E_RANGE = 3'd2;
    localparam logic [2:0] E_CMD   = 3'd3;
    localparam logic [2:0] E_SUM   = 3'd4;
    localparam logic [2:0] E_END   = 3'd5;

    // Event kinds passed from the parser to the decoder.
    localparam logic [1:0] EV_NONE   = 2'd0;
    localparam logic [1:0] EV_OPEN   = 2'd1;
    localparam logic [1:0] EV_ERR    = 2'd2;
    localparam logic [1:0] EV_DECODE = 2'd3;

    // Legal period modes.
    localparam logic [7:0] PERIOD_SEL_ONE   = 8'd1;
    localparam logic [7:0] PERIOD_SEL_THREE = 8'd3;
    localparam logic [1:0] PERIOD_SEL_IDLE  = 2'd1;

    typedef struct packed {
        logic [7:0] start_byte;
        logic [7:0] end_byte;
        logic [7:0] period_code;
        logic [7:0] view_code;
        logic [7:0] highest_view;
        logic [7:0] default_view;
    } cfg_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [2:0] err;
        logic [7:0] cmd;
        logic       len_one;
        logic [7:0] first;
    } event_t;

endpackage

[rtl/fcr_if.sv]
interface fcr_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

interface fcr_result_if;
    logic       valid;
    logic       ready;
    logic [1:0] status;
    logic [2:0] error_code;
    logic [7:0] command;
    logic [7:0] view;
    logic [1:0] period_sel;

    modport source (output valid, output status, output error_code, output command,
                    output view, output period_sel, input ready);
    modport sink (input valid, input status, input error_code, input command,
                  input view, input period_sel, output ready);
endinterface

[rtl/fcr_queue.sv]
`include "framed_command_receiver_assert.svh"

module fcr_queue
    import fcr_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEFAULT
)
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  event_t push_data,
    output logic   full,
    input  logic   pop,
    output event_t pop_data,
    output logic   empty
);

    localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CntW = $clog2(DEPTH + 1);

    event_t            entry_reg [DEPTH];
    logic [PtrW-1:0]   wr_ptr_reg;
    logic [PtrW-1:0]   wr_ptr_next;
    logic [PtrW-1:0]   rd_ptr_reg;
    logic [PtrW-1:0]   rd_ptr_next;
    logic [CntW-1:0]   count_reg;
    logic [CntW-1:0]   count_next;

    assign full     = (count_reg == CntW'(DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    `FCR_ASSERT_SAME(a_count_bound, 1'b1, count_reg <= CntW'(DEPTH), "queue count overflow")
    `FCR_ASSERT_NEXT(a_count_up, push && !pop, count_reg == $past(count_reg) + 1'b1, "queue count did not rise")
    `FCR_ASSERT_SAME(a_no_pop_empty, pop, !empty, "pop from empty queue")

endmodule

[rtl/fcr_front.sv]
module fcr_front
    import fcr_pkg::*;
#(
    parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEFAULT
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  cfg_t     cfg,
    fcr_byte_if.sink rx,
    output logic     push,
    output event_t   push_data,
    input  logic     full
);

    localparam logic [2:0] PH_WAIT  = 3'd0;
    localparam logic [2:0] PH_CMD   = 3'd1;
    localparam logic [2:0] PH_LEN   = 3'd2;
    localparam logic [2:0] PH_DATA  = 3'd3;
    localparam logic [2:0] PH_CHECK = 3'd4;
    localparam logic [2:0] PH_END   = 3'd5;

    localparam logic [7:0] MaxLen = 8'(MAX_PAYLOAD);

    logic [2:0] phase_reg;
    logic [2:0] phase_next;
    logic [7:0] held_reg;
    logic [7:0] held_next;
    logic [7:0] len_reg;
    logic [7:0] len_next;
    logic [7:0] count_reg;
    logic [7:0] count_next;
    logic [7:0] sum_reg;
    logic [7:0] sum_next;
    logic [7:0] first_reg;
    logic [7:0] first_next;

    logic       accept;
    logic       is_start;
    logic       restart;
    logic [7:0] count_inc;
    logic [7:0] b;

    assign rx.ready  = !full;
    assign accept    = rx.valid && !full;
    assign push      = accept;
    assign b         = rx.rx_byte;
    assign is_start  = (b == cfg.start_byte);
    assign count_inc = count_reg + 8'd1;

    always_comb
    begin
        phase_next = phase_reg;
        held_next  = held_reg;
        len_next   = len_reg;
        count_next = count_reg;
        sum_next   = sum_reg;
        first_next = first_reg;
        restart    = 1'b0;

        push_data.kind    = EV_NONE;
        push_data.err     = E_NONE;
        push_data.cmd     = held_reg;
        push_data.len_one = (len_reg == 8'd1);
        push_data.first   = first_reg;

        if (accept)
        begin
            unique case (phase_reg)
                PH_WAIT:
                begin
                    if (is_start)
                    begin
                        held_next      = '0;
                        len_next       = '0;
                        count_next     = '0;
                        sum_next       = cfg.start_byte;
                        phase_next     = PH_CMD;
                        push_data.kind = EV_OPEN;
                    end
                end
                PH_CMD:
                begin
                    held_next  = b;
                    sum_next   = sum_reg + b;
                    phase_next = PH_LEN;
                end
                PH_LEN:
                begin
                    len_next   = b;
                    sum_next   = sum_reg + b;
                    count_next = '0;
                    if (b > MaxLen)
                    begin
                        push_data.kind = EV_ERR;
                        push_data.err  = E_LEN;
                        restart        = 1'b1;
                    end
                    else
                    begin
                        phase_next = (b == 8'd0) ? PH_CHECK : PH_DATA;
                    end
                end
                PH_DATA:
                begin
                    if (count_reg == 8'd0)
                    begin
                        first_next = b;
                    end
                    count_next = count_inc;
                    sum_next   = sum_reg + b;
                    if (count_inc >= len_reg)
                    begin
                        phase_next = PH_CHECK;
                    end
                end
                PH_CHECK:
                begin
                    if (sum_reg != b)
                    begin
                        push_data.kind = EV_ERR;
                        push_data.err  = E_SUM;
                        restart        = 1'b1;
                    end
                    else
                    begin
                        phase_next = PH_END;
                    end
                end
                PH_END:
                begin
                    if (b != cfg.end_byte)
                    begin
                        push_data.kind = EV_ERR;
                        push_data.err  = E_END;
                        restart        = 1'b1;
                    end
                    else
                    begin
                        push_data.kind = EV_DECODE;
                        phase_next     = PH_WAIT;
                    end
                end
                default:
                begin
                    phase_next     = PH_WAIT;
                    push_data.kind = EV_ERR;
                    push_data.err  = E_CMD;
                end
            endcase

            // After an error the offending byte may itself open the next frame.
            if (restart)
            begin
                if (is_start)
                begin
                    held_next  = '0;
                    len_next   = '0;
                    count_next = '0;
                    sum_next   = cfg.start_byte;
                    phase_next = PH_CMD;
                end
                else
                begin
                    phase_next = PH_WAIT;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_WAIT;
            held_reg  <= '0;
            len_reg   <= '0;
            count_reg <= '0;
            sum_reg   <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            held_reg  <= held_next;
            len_reg   <= len_next;
            count_reg <= count_next;
            sum_reg   <= sum_next;
        end
    end

    always_ff @(posedge clk)
    begin
        first_reg <= first_next;
    end

endmodule

[rtl/fcr_back.sv]
`include "framed_command_receiver_assert.svh"

module fcr_back
    import fcr_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  cfg_t          cfg,
    input  event_t        ev,
    input  logic          empty,
    output logic          pop,
    fcr_result_if.source  result
);

    logic       out_valid_reg;
    logic       out_valid_next;
    logic [2:0] latch_reg;
    logic [2:0] latch_next;
    logic [1:0] status_reg;
    logic [7:0] command_reg;
    logic [7:0] view_reg;
    logic [1:0] period_reg;

    logic [1:0] status_d;
    logic [7:0] command_d;
    logic [7:0] view_d;
    logic [1:0] period_d;
    logic [2:0] err_d;

    // The output register is refilled in the same cycle that it is taken.
    assign pop = !empty && (!out_valid_reg || result.ready);

    always_comb
    begin
        latch_next = latch_reg;
        status_d   = ST_NONE;
        command_d  = '0;
        view_d     = cfg.default_view;
        period_d   = PERIOD_SEL_IDLE;
        err_d      = E_NONE;

        if (pop)
        begin
            unique case (ev.kind)
                EV_NONE:
                begin
                end
                EV_OPEN:
                begin
                    latch_next = E_NONE;
                end
                EV_ERR:
                begin
                    latch_next = ev.err;
                    status_d   = ST_ERR;
                end
                EV_DECODE:
                begin
                    command_d = ev.cmd;
                    // Set-period wins when both command codes are equal.
                    priority if (ev.cmd == cfg.period_code)
                    begin
                        if (!ev.len_one)
                        begin
                            err_d = E_LEN;
                        end
                        else if (ev.first != PERIOD_SEL_ONE && ev.first != PERIOD_SEL_THREE)
                        begin
                            err_d = E_RANGE;
                        end
                        else
                        begin
                            period_d = ev.first[1:0];
                        end
                    end
                    else if (ev.cmd == cfg.view_code)
                    begin
                        if (!ev.len_one)
                        begin
                            err_d = E_LEN;
                        end
                        else if (ev.first > cfg.highest_view)
                        begin
                            err_d = E_RANGE;
                        end
                        else
                        begin
                            view_d = ev.first;
                        end
                    end
                    else
                    begin
                        err_d = E_CMD;
                    end
                    latch_next = err_d;
                    status_d   = (err_d == E_NONE) ? ST_OK : ST_ERR;
                end
            endcase
        end
    end

    always_comb
    begin
        if (pop)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            latch_reg     <= E_NONE;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            latch_reg     <= latch_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            status_reg  <= status_d;
            command_reg <= command_d;
            view_reg    <= view_d;
            period_reg  <= period_d;
        end
    end

    assign result.valid      = out_valid_reg;
    assign result.status     = status_reg;
    assign result.error_code = latch_reg;
    assign result.command    = command_reg;
    assign result.view       = view_reg;
    assign result.period_sel = period_reg;

    `FCR_ASSERT_NEXT(a_open_clears, pop && ev.kind == EV_OPEN,
        result.valid && result.error_code == E_NONE, "frame open did not clear the error")
    `FCR_ASSERT_NEXT(a_err_status, pop && ev.kind == EV_ERR,
        result.status == ST_ERR, "error event not reported")
    `FCR_ASSERT_NEXT(a_stall_holds_latch, result.valid && !result.ready,
        latch_reg == $past(latch_reg), "error latch moved during stall")

endmodule

[rtl/framed_command_receiver.sv]
// Channel   Direction  Word contents
// rx        in         rx_byte: one received byte
// result    out        status, error_code, command, view, period_sel
// cfg_*     in         write enable, register index, write data (no read-back)
//
// One byte is accepted every cycle while the event queue is not full; its result
// word is registered in the event queue and then in the output register, so the
// sustained rate is one byte per clock unless the result side stalls. The parser
// updates its frame state per byte; the decoder makes one result word per event.
// Reset is asynchronous and active low and returns the parser to waiting for a
// start byte with the configuration at its defaults; no clearing pass is needed.
// A stall on the result side fills the event queue, and rx.ready drops only when
// the queue is full.
module framed_command_receiver
    import fcr_pkg::*;
#(
    parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEFAULT,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    fcr_byte_if.sink               rx,
    fcr_result_if.source           result,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [7:0]             cfg_wdata
);

    cfg_t   cfg_reg;
    event_t push_data;
    event_t pop_data;
    logic   push;
    logic   pop;
    logic   full;
    logic   empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_byte   <= START_BYTE_RST;
            cfg_reg.end_byte     <= END_BYTE_RST;
            cfg_reg.period_code  <= PERIOD_CODE_RST;
            cfg_reg.view_code    <= VIEW_CODE_RST;
            cfg_reg.highest_view <= HIGHEST_VIEW_RST;
            cfg_reg.default_view <= DEFAULT_VIEW_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_START_BYTE:   cfg_reg.start_byte   <= cfg_wdata;
                CFG_END_BYTE:     cfg_reg.end_byte     <= cfg_wdata;
                CFG_PERIOD_CODE:  cfg_reg.period_code  <= cfg_wdata;
                CFG_VIEW_CODE:    cfg_reg.view_code    <= cfg_wdata;
                CFG_HIGHEST_VIEW: cfg_reg.highest_view <= cfg_wdata;
                CFG_DEFAULT_VIEW: cfg_reg.default_view <= cfg_wdata;
                default:
                begin
                end
            endcase
        end
    end

    fcr_front #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .rx        (rx),
        .push      (push),
        .push_data (push_data),
        .full      (full)
    );

    fcr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (full),
        .pop       (pop),
        .pop_data  (pop_data),
        .empty     (empty)
    );

    fcr_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_reg),
        .ev     (pop_data),
        .empty  (empty),
        .pop    (pop),
        .result (result)
    );

endmodule

[sim/testbench.sv]
`timescale 1ns / 100ps

module testbench;
    import fcr_pkg::*;

    localparam int CYCLE_LIMIT     = 400000;
    localparam int ITEMS_PER_PHASE = 75;
    localparam int HOLD_CYCLES     = 150;
    localparam int SETTING_COUNT   = 6;
    localparam int RANDOM_SETTING  = 4;
    localparam int HOLD_SETTING    = 2;

    typedef enum logic [2:0] {
        WAIT_SOF,
        GET_CMD,
        GET_LEN,
        GET_DATA,
        GET_SUM,
        GET_EOF
    } parse_phase_t;

    typedef struct packed {
        logic [1:0] status;
        logic [2:0] error_code;
        logic [7:0] command;
        logic [7:0] view;
        logic [1:0] period_sel;
    } result_word_t;

    typedef struct packed {
        logic [7:0]   data;
        logic         typed;
        result_word_t want;
    } stim_row_t;

    localparam result_word_t IDLE_WORD = {ST_NONE, E_NONE, 8'h00, 8'h00, PERIOD_SEL_IDLE};

    // Directed frames, all under the reset configuration.
    localparam stim_row_t DIRECTED_ROWS [0:24] = '{
        {8'h00, 1'b1, IDLE_WORD},
        {8'hAA, 1'b1, IDLE_WORD},
        // Set-period to mode 3.
        {8'h01, 1'b0, IDLE_WORD},
        {8'h01, 1'b0, IDLE_WORD},
        {8'h03, 1'b0, IDLE_WORD},
        {8'hAF, 1'b0, IDLE_WORD},
        {8'h55, 1'b1, {ST_OK, E_NONE, 8'h01, 8'h00, 2'd3}},
        // Set-view to the highest view.
        {8'hAA, 1'b0, IDLE_WORD},
        {8'h02, 1'b0, IDLE_WORD},
        {8'h01, 1'b0, IDLE_WORD},
        {8'h02, 1'b0, IDLE_WORD},
        {8'hAF, 1'b0, IDLE_WORD},
        {8'h55, 1'b1, {ST_OK, E_NONE, 8'h02, 8'h02, 2'd1}},
        // Unknown command with an empty payload.
        {8'hAA, 1'b0, IDLE_WORD},
        {8'h07, 1'b0, IDLE_WORD},
        {8'h00, 1'b0, IDLE_WORD},
        {8'hB1, 1'b0, IDLE_WORD},
        {8'h55, 1'b1, {ST_ERR, E_CMD, 8'h07, 8'h00, 2'd1}},
        // Over-long length that is itself a start byte, then a bad end byte.
        {8'hAA, 1'b0, IDLE_WORD},
        {8'h01, 1'b0, IDLE_WORD},
        {8'hAA, 1'b1, {ST_ERR, E_LEN, 8'h00, 8'h00, 2'd1}},
        {8'h02, 1'b0, IDLE_WORD},
        {8'h00, 1'b0, IDLE_WORD},
        {8'hAC, 1'b0, IDLE_WORD},
        {8'h00, 1'b1, {ST_ERR, E_END, 8'h00, 8'h00, 2'd1}}
    };

    localparam cfg_t SETTING_LIST [0:SETTING_COUNT-1] = '{
        {8'hAA, 8'h55, 8'h01, 8'h02, 8'h02, 8'h00},
        {8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF},
        {8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00},
        {8'h7E, 8'h7E, 8'h10, 8'h10, 8'h05, 8'h03},
        {8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        {8'h05, 8'hC3, 8'h40, 8'h41, 8'h80, 8'h7F}
    };

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [7:0]             cfg_wdata;

    fcr_byte_if   rx_ch ();
    fcr_result_if res_ch ();

    framed_command_receiver u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .rx        (rx_ch.sink),
        .result    (res_ch.source),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #5 clk = ~clk;

    // Shadow of the configuration and of the parser state.
    cfg_t         shadow_cfg  = {START_BYTE_RST, END_BYTE_RST, PERIOD_CODE_RST,
                                 VIEW_CODE_RST, HIGHEST_VIEW_RST, DEFAULT_VIEW_RST};
    parse_phase_t track_phase = WAIT_SOF;
    logic [7:0]   track_cmd   = 8'd0;
    logic [7:0]   track_len   = 8'd0;
    logic [7:0]   track_count = 8'd0;
    logic [7:0]   track_sum   = 8'd0;
    logic [7:0]   track_first = 8'd0;
    logic [2:0]   track_err   = E_NONE;

    result_word_t expected_words [$];
    int           mismatches    = 0;
    int           bytes_sent    = 0;
    int           words_taken   = 0;
    int           cycle_count   = 0;
    bit           tx_calm       = 1'b0;
    bit           rx_calm       = 1'b0;
    bit           hold_off_req  = 1'b0;

    function automatic int draw_wait(bit calm);
        if (calm)
            return 0;
        return int'($urandom_range(0, 17));
    endfunction

    function automatic void note_failure(string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("%s", msg);
    endfunction

    function automatic void reopen_or_wait(logic [7:0] b);
        if (b == shadow_cfg.start_byte)
        begin
            track_cmd   = 8'd0;
            track_len   = 8'd0;
            track_count = 8'd0;
            track_sum   = shadow_cfg.start_byte;
            track_phase = GET_CMD;
        end
        else
            track_phase = WAIT_SOF;
    endfunction

    function automatic result_word_t predict_word(logic [7:0] b);
        result_word_t w;
        logic [2:0]   verdict;
        w.status     = ST_NONE;
        w.error_code = E_NONE;
        w.command    = 8'd0;
        w.view       = shadow_cfg.default_view;
        w.period_sel = PERIOD_SEL_IDLE;
        verdict      = E_NONE;
        case (track_phase)
            WAIT_SOF:
            begin
                if (b == shadow_cfg.start_byte)
                    track_err = E_NONE;
                reopen_or_wait(b);
            end
            GET_CMD:
            begin
                track_cmd   = b;
                track_sum   = track_sum + b;
                track_phase = GET_LEN;
            end
            GET_LEN:
            begin
                track_len   = b;
                track_sum   = track_sum + b;
                track_count = 8'd0;
                if (int'(b) > MAX_PAYLOAD_DEFAULT)
                begin
                    track_err = E_LEN;
                    reopen_or_wait(b);
                    w.status = ST_ERR;
                end
                else
                    track_phase = (b == 8'd0) ? GET_SUM : GET_DATA;
            end
            GET_DATA:
            begin
                if (track_count == 8'd0)
                    track_first = b;
                track_count = track_count + 8'd1;
                track_sum   = track_sum + b;
                if (track_count >= track_len)
                    track_phase = GET_SUM;
            end
            GET_SUM:
            begin
                if (track_sum != b)
                begin
                    track_err = E_SUM;
                    reopen_or_wait(b);
                    w.status = ST_ERR;
                end
                else
                    track_phase = GET_EOF;
            end
            GET_EOF:
            begin
                if (b != shadow_cfg.end_byte)
                begin
                    track_err = E_END;
                    reopen_or_wait(b);
                    w.status = ST_ERR;
                end
                else
                begin
                    w.command = track_cmd;
                    // Set-period wins when both command codes are equal.
                    if (track_cmd == shadow_cfg.period_code)
                    begin
                        if (track_len != 8'd1)
                            verdict = E_LEN;
                        else if (track_first != PERIOD_SEL_ONE &&
                                 track_first != PERIOD_SEL_THREE)
                            verdict = E_RANGE;
                        else
                            w.period_sel = track_first[1:0];
                    end
                    else if (track_cmd == shadow_cfg.view_code)
                    begin
                        if (track_len != 8'd1)
                            verdict = E_LEN;
                        else if (track_first > shadow_cfg.highest_view)
                            verdict = E_RANGE;
                        else
                            w.view = track_first;
                    end
                    else
                        verdict = E_CMD;
                    track_err   = verdict;
                    track_phase = WAIT_SOF;
                    w.status    = (verdict == E_NONE) ? ST_OK : ST_ERR;
                end
            end
            default:
            begin
                track_phase = WAIT_SOF;
                track_err   = E_CMD;
                w.status    = ST_ERR;
            end
        endcase
        w.error_code = track_err;
        return w;
    endfunction

    // Offers one byte and records the word it must produce once it is taken.
    task automatic send_byte(logic [7:0] b, result_word_t want, logic typed);
        int           gap;
        result_word_t predicted;
        gap = draw_wait(tx_calm);
        if (gap > 0)
        begin
            rx_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        rx_ch.valid   <= 1'b1;
        rx_ch.rx_byte <= b;
        do
            @(posedge clk);
        while (!rx_ch.ready);
        predicted = predict_word(b);
        expected_words.push_back(typed ? want : predicted);
        bytes_sent++;
    endtask

    task automatic send_frame();
        logic [7:0] frame_bytes [$];
        logic [7:0] cmd;
        logic [7:0] len;
        logic [7:0] first;
        logic [7:0] sum;
        logic [7:0] body;
        int         pick;
        int         nbody;
        pick = int'($urandom_range(0, 9));
        if (pick < 4)
            cmd = shadow_cfg.period_code;
        else if (pick < 8)
            cmd = shadow_cfg.view_code;
        else
            cmd = 8'($urandom());
        pick = int'($urandom_range(0, 11));
        if (pick < 8)
            len = 8'd1;
        else if (pick < 10)
            len = 8'($urandom_range(0, MAX_PAYLOAD_DEFAULT));
        else if (pick == 10)
            len = 8'($urandom_range(MAX_PAYLOAD_DEFAULT + 1, 255));
        else
            len = shadow_cfg.start_byte;
        pick = int'($urandom_range(0, 5));
        if (cmd == shadow_cfg.period_code)
            first = (pick < 2) ? PERIOD_SEL_ONE : (pick < 4) ? PERIOD_SEL_THREE
                                                            : 8'($urandom());
        else if (pick < 4)
            first = 8'($urandom_range(0, int'(shadow_cfg.highest_view)));
        else if (pick == 4)
            first = shadow_cfg.highest_view + 8'd1;
        else
            first = 8'($urandom());
        frame_bytes = {shadow_cfg.start_byte, cmd, len};
        sum = shadow_cfg.start_byte + cmd + len;
        nbody = (int'(len) > MAX_PAYLOAD_DEFAULT) ? 0 : int'(len);
        for (int i = 0; i < nbody; i++)
        begin
            body = (i == 0) ? first : 8'($urandom());
            frame_bytes.push_back(body);
            sum = sum + body;
        end
        // A broken checksum or end byte is sometimes the start byte, which reopens.
        pick = int'($urandom_range(0, 19));
        if (pick == 0)
            frame_bytes.push_back(shadow_cfg.start_byte);
        else if (pick == 1)
            frame_bytes.push_back(sum ^ 8'(1 << $urandom_range(0, 7)));
        else
            frame_bytes.push_back(sum);
        pick = int'($urandom_range(0, 19));
        if (pick == 0)
            frame_bytes.push_back(shadow_cfg.start_byte);
        else if (pick == 1)
            frame_bytes.push_back(shadow_cfg.end_byte ^ 8'(1 << $urandom_range(0, 7)));
        else
            frame_bytes.push_back(shadow_cfg.end_byte);
        foreach (frame_bytes[i])
            send_byte(frame_bytes[i], IDLE_WORD, 1'b0);
    endtask

    task automatic wait_drained();
        rx_ch.valid <= 1'b0;
        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic put_reg(logic [CFG_INDEX_W-1:0] idx, logic [7:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        case (idx)
            CFG_START_BYTE:   shadow_cfg.start_byte   = val;
            CFG_END_BYTE:     shadow_cfg.end_byte     = val;
            CFG_PERIOD_CODE:  shadow_cfg.period_code  = val;
            CFG_VIEW_CODE:    shadow_cfg.view_code    = val;
            CFG_HIGHEST_VIEW: shadow_cfg.highest_view = val;
            CFG_DEFAULT_VIEW: shadow_cfg.default_view = val;
            default: ;
        endcase
    endtask

    task automatic apply_settings(cfg_t s);
        put_reg(CFG_START_BYTE, s.start_byte);
        put_reg(CFG_END_BYTE, s.end_byte);
        put_reg(CFG_PERIOD_CODE, s.period_code);
        put_reg(CFG_VIEW_CODE, s.view_code);
        put_reg(CFG_HIGHEST_VIEW, s.highest_view);
        put_reg(CFG_DEFAULT_VIEW, s.default_view);
        cfg_we <= 1'b0;
    endtask

    initial
    begin : stimulus
        cfg_t s;
        int   phase_end;
        rst_n         <= 1'b0;
        cfg_we        <= 1'b0;
        cfg_index     <= '0;
        cfg_wdata     <= 8'd0;
        rx_ch.valid   <= 1'b0;
        rx_ch.rx_byte <= 8'd0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        foreach (DIRECTED_ROWS[i])
            send_byte(DIRECTED_ROWS[i].data, DIRECTED_ROWS[i].want, DIRECTED_ROWS[i].typed);

        for (int p = 0; p < SETTING_COUNT; p++)
        begin
            s = SETTING_LIST[p];
            if (p == RANDOM_SETTING)
                s = cfg_t'(48'({$urandom(), $urandom()}));
            wait_drained();
            apply_settings(s);
            // The receiver stops taking words for a while so the input backs up.
            if (p == HOLD_SETTING)
                hold_off_req = 1'b1;
            phase_end = bytes_sent + ITEMS_PER_PHASE;
            while (bytes_sent < phase_end)
            begin
                tx_calm = ($urandom_range(0, 4) == 0);
                if ($urandom_range(0, 2) == 0)
                    repeat ($urandom_range(1, 4)) send_byte(8'($urandom()), IDLE_WORD, 1'b0);
                send_frame();
            end
        end

        wait_drained();
        repeat (4) @(posedge clk);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin : collector
        int           stall;
        result_word_t got;
        result_word_t want;
        res_ch.ready <= 1'b0;
        forever
        begin
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                res_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                stall = draw_wait(rx_calm);
                if (stall > 0)
                begin
                    res_ch.ready <= 1'b0;
                    repeat (stall) @(posedge clk);
                end
            end
            res_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!res_ch.valid);
            got = {res_ch.status, res_ch.error_code, res_ch.command, res_ch.view,
                   res_ch.period_sel};
            words_taken++;
            if (words_taken % 32 == 0)
                rx_calm = ($urandom_range(0, 3) == 0);
            if (expected_words.size() == 0)
                note_failure($sformatf("word %0d arrived with nothing expected", words_taken));
            else
            begin
                want = expected_words.pop_front();
                if (got.status !== want.status || got.error_code !== want.error_code ||
                    got.command !== want.command || got.view !== want.view ||
                    got.period_sel !== want.period_sel)
                    note_failure($sformatf(
                        "word %0d: expected %0d/%0d/%02h/%02h/%0d, got %0d/%0d/%02h/%02h/%0d",
                        words_taken, want.status, want.error_code, want.command, want.view,
                        want.period_sel, got.status, got.error_code, got.command, got.view,
                        got.period_sel));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

endmodule

[files.f]
+incdir+rtl
rtl/fcr_pkg.sv
rtl/fcr_if.sv
rtl/fcr_queue.sv
rtl/fcr_front.sv
rtl/fcr_back.sv
rtl/framed_command_receiver.sv
sim/testbench.sv
